@@ design/ili_pkg.sv @@
`timescale 1ns / 1ps
// ili_pkg: shared constants, codes and types of the indexed list store
// no dependencies; used by the interfaces and every module of the block

package ili_pkg;

	localparam int CAPACITY = 1024;
	localparam int AW       = $clog2(CAPACITY);
	localparam int CW       = $clog2(CAPACITY + 1);
	localparam int PW       = 16;
	localparam int DW       = 32;

	typedef enum logic [1:0] {
		REQ_READ   = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_APPEND = 2'd2,
		REQ_DELETE = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_MOVE,
		S_PUT,
		S_REPLY
	} seq_state_t;

	// one port set of the value store
	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [DW-1:0] wdata;
		logic [AW-1:0] raddr;
	} mem_req_t;

	// finished result handed from the sequencer to the output register
	typedef struct packed {
		logic                 done;
		logic signed [DW-1:0] read_value;
		logic [1:0]           status;
		logic [CW-1:0]        count_after;
	} seq_res_t;

endpackage

@@ design/ili_if.sv @@
`timescale 1ns / 1ps
// ili_req_if and ili_rsp_if: valid/ready channels of the indexed list store
// depends on ili_pkg for field widths

interface ili_req_if;
	import ili_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [1:0]           req_type;
	logic signed [PW-1:0] position;
	logic signed [DW-1:0] value;

	modport source (output valid, output req_type, output position, output value, input ready);
	modport sink (input valid, input req_type, input position, input value, output ready);
endinterface

interface ili_rsp_if;
	import ili_pkg::*;

	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] read_value;
	logic [1:0]           status;
	logic [CW-1:0]        count_after;

	modport source (output valid, output read_value, output status, output count_after,
		input ready);
	modport sink (input valid, input read_value, input status, input count_after,
		output ready);
endinterface

@@ design/ili_store.sv @@
`timescale 1ns / 1ps
// ili_store: value store, one write and one registered read per cycle
// depends on ili_pkg

module ili_store (
	input  logic              clk,
	input  ili_pkg::mem_req_t mreq,
	output logic [ili_pkg::DW-1:0] rdata
);
	import ili_pkg::*;

	logic [DW-1:0] mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem_q[mreq.waddr] <= mreq.wdata;
		end
		rdata <= mem_q[mreq.raddr];
	end

endmodule

@@ design/ili_seq.sv @@
`timescale 1ns / 1ps
// ili_seq: request decode, entry count and the one-entry-a-cycle move sequencer
// depends on ili_pkg; drives the port set of ili_store

module ili_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [1:0]                    req_type,
	input  logic signed [ili_pkg::PW-1:0] position,
	input  logic signed [ili_pkg::DW-1:0] value,
	input  logic                          slot_free,
	input  logic [ili_pkg::DW-1:0]        rdata,
	output logic                          idle,
	output ili_pkg::mem_req_t             mreq,
	output ili_pkg::seq_res_t             res
);
	import ili_pkg::*;

	seq_state_t    state_q, state_nxt;
	req_kind_t     kind_q, kind_nxt;
	logic [CW-1:0] count_q, count_nxt;
	logic [CW-1:0] remain_q, remain_nxt;
	logic [AW-1:0] ptr_q, ptr_nxt;
	logic [AW-1:0] wa_q, wa_nxt;
	logic [AW-1:0] at_q, at_nxt;
	logic          pend_q, pend_nxt;
	logic [DW-1:0] value_q, value_nxt;
	logic [DW-1:0] rval_q, rval_nxt;
	logic [1:0]    stat_q, stat_nxt;

	logic          pos_neg, in_range, beyond, full;
	logic [PW-1:0] pos_ext, cnt_ext;
	logic [AW-1:0] pos_a, at_sel;
	logic [CW-1:0] cnt_m1;

	assign pos_neg  = position[PW-1];
	assign pos_ext  = {1'b0, position[PW-2:0]};
	assign cnt_ext  = PW'(count_q);
	assign in_range = !pos_neg && (pos_ext < cnt_ext);
	assign beyond   = !pos_neg && (pos_ext > cnt_ext);
	assign full     = (count_q == CW'(CAPACITY));
	assign pos_a    = position[AW-1:0];
	assign cnt_m1   = count_q - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			remain_q <= '0;
			pend_q   <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			count_q  <= count_nxt;
			remain_q <= remain_nxt;
			pend_q   <= pend_nxt;
		end
	end

	always_ff @(posedge clk) begin
		kind_q  <= kind_nxt;
		ptr_q   <= ptr_nxt;
		wa_q    <= wa_nxt;
		at_q    <= at_nxt;
		value_q <= value_nxt;
		rval_q  <= rval_nxt;
		stat_q  <= stat_nxt;
	end

	always_comb begin
		state_nxt  = state_q;
		kind_nxt   = kind_q;
		count_nxt  = count_q;
		remain_nxt = remain_q;
		ptr_nxt    = ptr_q;
		wa_nxt     = wa_q;
		at_nxt     = at_q;
		pend_nxt   = pend_q;
		value_nxt  = value_q;
		rval_nxt   = rval_q;
		stat_nxt   = stat_q;
		at_sel     = pos_neg ? '0 : pos_a;
		idle       = 1'b0;
		mreq.we    = 1'b0;
		mreq.waddr = wa_q;
		mreq.wdata = rdata;
		mreq.raddr = ptr_q;
		res.done        = 1'b0;
		res.read_value  = rval_q;
		res.status      = stat_q;
		res.count_after = count_q;

		unique case (state_q)
			S_IDLE: begin
				idle       = 1'b1;
				mreq.raddr = pos_a;
				if (fire) begin
					kind_nxt  = req_kind_t'(req_type);
					value_nxt = value;
					rval_nxt  = '0;
					stat_nxt  = STAT_DONE;
					pend_nxt  = 1'b0;
					unique case (req_kind_t'(req_type))
						REQ_READ: begin
							if (in_range) begin
								state_nxt = S_READ;
							end else begin
								rval_nxt  = '1;
								stat_nxt  = STAT_RANGE;
								state_nxt = S_REPLY;
							end
						end
						REQ_INSERT, REQ_APPEND: begin
							if (req_kind_t'(req_type) == REQ_APPEND) begin
								at_sel = count_q[AW-1:0];
							end
							if (req_kind_t'(req_type) == REQ_INSERT && beyond) begin
								stat_nxt  = STAT_RANGE;
								state_nxt = S_REPLY;
							end else if (full) begin
								stat_nxt  = STAT_FULL;
								state_nxt = S_REPLY;
							end else begin
								// tail entries move up one place, last one first
								at_nxt     = at_sel;
								ptr_nxt    = cnt_m1[AW-1:0];
								remain_nxt = count_q - CW'(at_sel);
								count_nxt  = count_q + CW'(1);
								state_nxt  = S_MOVE;
							end
						end
						REQ_DELETE: begin
							if (in_range) begin
								// entries above the gap move down, nearest first
								ptr_nxt    = pos_a + AW'(1);
								remain_nxt = cnt_m1 - CW'(pos_a);
								count_nxt  = cnt_m1;
								state_nxt  = S_MOVE;
							end else begin
								stat_nxt  = STAT_RANGE;
								state_nxt = S_REPLY;
							end
						end
						default: state_nxt = S_REPLY;
					endcase
				end
			end
			S_READ: begin
				rval_nxt  = rdata;
				state_nxt = S_REPLY;
			end
			S_MOVE: begin
				// write back the entry read last cycle while fetching the next
				mreq.we = pend_q;
				if (remain_q != '0) begin
					remain_nxt = remain_q - CW'(1);
					pend_nxt   = 1'b1;
					if (kind_q == REQ_DELETE) begin
						wa_nxt  = ptr_q - AW'(1);
						ptr_nxt = ptr_q + AW'(1);
					end else begin
						wa_nxt  = ptr_q + AW'(1);
						ptr_nxt = ptr_q - AW'(1);
					end
				end else begin
					pend_nxt  = 1'b0;
					state_nxt = (kind_q == REQ_DELETE) ? S_REPLY : S_PUT;
				end
			end
			S_PUT: begin
				mreq.we    = 1'b1;
				mreq.waddr = at_q;
				mreq.wdata = value_q;
				state_nxt  = S_REPLY;
			end
			S_REPLY: begin
				if (slot_free) begin
					res.done  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule

@@ design/indexed_list_insert_delete.sv @@
`timescale 1ns / 1ps
// Indexed list store: holds up to CAPACITY signed values in order with a count, and
// takes one request at a time (read, insert at position, append, delete at position),
// answering each with exactly one result beat. A read passes through the read state to
// the reply state; a refused request goes straight to the reply state. An insert or a
// delete first shifts the tail of the list by one place in the move state, one entry
// per cycle through the single value memory's one read and one write port (an append
// is an insert at p = n); an insert then writes the new value in the put state. The
// request side is ready again the cycle after the result is handed to the output
// register; a finished result sits in that register and the next request is taken
// while it waits. No clearing pass is needed after reset: only entries below the count
// are ever used.
// depends on ili_pkg, ili_req_if, ili_rsp_if, ili_store and ili_seq

module indexed_list_insert_delete (
	input logic clk,
	input logic arst_n,
	ili_req_if.sink   req,
	ili_rsp_if.source rsp
);
	import ili_pkg::*;

	mem_req_t      mreq;
	seq_res_t      res;
	logic [DW-1:0] rdata;
	logic          seq_idle;
	logic          slot_free;

	logic                 out_valid_q;
	logic signed [DW-1:0] out_value_q;
	logic [1:0]           out_status_q;
	logic [CW-1:0]        out_count_q;

	assign req.ready = seq_idle;
	assign slot_free = !out_valid_q || rsp.ready;

	ili_store u_store (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	ili_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (req.valid && seq_idle),
		.req_type  (req.req_type),
		.position  (req.position),
		.value     (req.value),
		.slot_free (slot_free),
		.rdata     (rdata),
		.idle      (seq_idle),
		.mreq      (mreq),
		.res       (res)
	);

	// output register parts the result beat from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			out_value_q  <= res.read_value;
			out_status_q <= res.status;
			out_count_q  <= res.count_after;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = out_value_q;
	assign rsp.status      = out_status_q;
	assign rsp.count_after = out_count_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request side ready right after an accepted beat");

	a_done_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (!out_valid_q || rsp.ready))
		else $error("result overwrote a waiting beat");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_count_q <= CW'(CAPACITY)))
		else $error("count above capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == STAT_FULL) |-> (out_count_q == CW'(CAPACITY)))
		else $error("full status without a full store");

endmodule

@@ tb/sv/tb_indexed_list_insert_delete.sv @@
`timescale 1ns / 1ps
// tb_indexed_list_insert_delete: self-checking bench for the indexed list store, a list
// predictor in a scoreboard class plus randomised request traffic and response stalls
// depends on ili_pkg, ili_req_if, ili_rsp_if and indexed_list_insert_delete

module tb_indexed_list_insert_delete;
	import ili_pkg::*;

	localparam int CYCLE_LIMIT = 5_000_000;

	typedef struct {
		logic signed [DW-1:0] read_value;
		stat_t                status;
		logic [CW-1:0]        count_after;
	} list_result_t;

	// mirror of the stored sequence and the results still owed by the block
	class list_scoreboard;
		logic signed [DW-1:0] contents[$];
		list_result_t         awaited[$];
		int                   errors = 0;

		function void note_request(req_kind_t kind, logic signed [PW-1:0] pos,
			logic signed [DW-1:0] val);
			int           p;
			int           n;
			list_result_t res;
			p = pos;
			n = contents.size();
			res.read_value = '0;
			res.status     = STAT_DONE;
			case (kind)
				REQ_READ: begin
					if (p >= 0 && p < n) begin
						res.read_value = contents[p];
					end else begin
						res.read_value = -1;
						res.status     = STAT_RANGE;
					end
				end
				REQ_INSERT: begin
					// beyond-count check wins over the full check
					if (p > n) begin
						res.status = STAT_RANGE;
					end else if (n >= CAPACITY) begin
						res.status = STAT_FULL;
					end else begin
						contents.insert((p <= 0) ? 0 : p, val);
					end
				end
				REQ_APPEND: begin
					if (n >= CAPACITY) begin
						res.status = STAT_FULL;
					end else begin
						contents.push_back(val);
					end
				end
				default: begin
					if (p >= 0 && p < n) begin
						contents.delete(p);
					end else begin
						res.status = STAT_RANGE;
					end
				end
			endcase
			res.count_after = CW'(contents.size());
			awaited.push_back(res);
		endfunction

		function void check_result(logic signed [DW-1:0] rv, logic [1:0] st,
			logic [CW-1:0] cnt);
			list_result_t want;
			if (awaited.size() == 0) begin
				$error("result beat with no request outstanding");
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (rv !== want.read_value) begin
				$error("read_value: expected %0d, got %0d", want.read_value, rv);
				errors++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				errors++;
			end
			if (cnt !== want.count_after) begin
				$error("count_after: expected %0d, got %0d", want.count_after, cnt);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   gap_pct   = 0;
	int   stall_pct = 0;
	int   cycle_count = 0;

	list_scoreboard sb = new();

	ili_req_if req_bus ();
	ili_rsp_if rsp_bus ();

	indexed_list_insert_delete u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [DW-1:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return -1;
			3:       return 0;
			default: return $urandom;
		endcase
	endfunction

	// hi is the highest position that is in range for the request
	function automatic logic signed [PW-1:0] pick_pos(int hi);
		case ($urandom_range(0, 9))
			0:       return PW'($urandom);
			1:       return PW'(-int'($urandom_range(1, 32768)));
			2:       return PW'(hi + 1);
			3:       return PW'(hi);
			default: return (hi < 0) ? '0 : PW'($urandom_range(0, hi));
		endcase
	endfunction

	task automatic send_req(req_kind_t kind, logic signed [PW-1:0] pos,
		logic signed [DW-1:0] val);
		if ($urandom_range(0, 99) < gap_pct) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_bus.valid    <= 1'b1;
		req_bus.req_type <= kind;
		req_bus.position <= pos;
		req_bus.value    <= val;
		do @(posedge clk); while (req_bus.ready !== 1'b1);
		sb.note_request(kind, pos, val);
	endtask

	task automatic random_item(int w_read, int w_ins, int w_app, int w_del);
		int                   n;
		int                   roll;
		req_kind_t            kind;
		logic signed [PW-1:0] pos;
		n    = sb.contents.size();
		roll = $urandom_range(0, w_read + w_ins + w_app + w_del - 1);
		if ($urandom_range(0, 19) == 0) begin
			// raw noise over the whole request space
			kind = req_kind_t'($urandom_range(0, 3));
			pos  = PW'($urandom);
		end else if (roll < w_read) begin
			kind = REQ_READ;
			pos  = pick_pos(n - 1);
		end else if (roll < w_read + w_ins) begin
			kind = REQ_INSERT;
			pos  = pick_pos(n);
		end else if (roll < w_read + w_ins + w_app) begin
			kind = REQ_APPEND;
			pos  = PW'($urandom);
		end else begin
			kind = REQ_DELETE;
			pos  = pick_pos(n - 1);
		end
		send_req(kind, pos, pick_value());
	endtask

	task automatic wait_for_results();
		req_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// response side: random ready stalls in bursts, checks every accepted beat
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
				sb.check_result(rsp_bus.read_value, rsp_bus.status, rsp_bus.count_after);
			if (stall_left > 0) begin
				stall_left--;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 16);
			end
			rsp_bus.ready <= (stall_left == 0);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n           <= 1'b0;
		req_bus.valid    <= 1'b0;
		req_bus.req_type <= REQ_READ;
		req_bus.position <= '0;
		req_bus.value    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, front/tail/middle inserts, range errors, deletes
		gap_pct   = 25;
		stall_pct = 10;
		send_req(REQ_READ, 0, 0);
		send_req(REQ_READ, 16'sh8000, 0);
		send_req(REQ_DELETE, 0, 0);
		send_req(REQ_INSERT, 1, 32'sh1234_5678);
		send_req(REQ_INSERT, -1, 32'sh7FFF_FFFF);
		send_req(REQ_INSERT, 16'sh8000, 32'sh8000_0000);
		send_req(REQ_APPEND, 16'sh7FFF, -1);
		send_req(REQ_INSERT, 3, 32'sh5555_5555);
		send_req(REQ_INSERT, 2, 32'shAAAA_AAAA);
		send_req(REQ_INSERT, 6, 32'sh0F0F_0F0F);
		send_req(REQ_INSERT, 16'sh7FFF, 32'shF0F0_F0F0);
		send_req(REQ_READ, 0, 0);
		send_req(REQ_READ, 4, 0);
		send_req(REQ_READ, 5, 0);
		send_req(REQ_READ, 16'sh7FFF, 0);
		send_req(REQ_READ, -1, 0);
		send_req(REQ_DELETE, 5, 0);
		send_req(REQ_DELETE, -1, 0);
		send_req(REQ_DELETE, 16'sh7FFF, 0);
		send_req(REQ_DELETE, 2, 0);
		send_req(REQ_DELETE, 0, 0);
		send_req(REQ_DELETE, 2, 0);
		send_req(REQ_READ, 0, 0);
		send_req(REQ_READ, 1, 0);
		wait_for_results();

		// mixed traffic at small counts, busy and quiet stretches in turn
		for (int i = 0; i < 500; i++) begin
			if (i % 100 == 0) begin
				gap_pct   = ((i / 100) % 2 == 0) ? 30 : 0;
				stall_pct = ((i / 100) % 2 == 0) ? 15 : 0;
			end
			random_item(30, 25, 20, 25);
		end
		wait_for_results();

		// boundary requests at the present count, no idling from here on
		gap_pct   = 0;
		stall_pct = 0;
		send_req(REQ_INSERT, PW'(sb.contents.size() + 1), 32'sh1111_1111);
		send_req(REQ_INSERT, PW'(sb.contents.size()), 32'sh2222_2222);
		send_req(REQ_INSERT, -5, 32'sh3333_3333);
		send_req(REQ_APPEND, 0, 32'sh4444_4444);
		send_req(REQ_READ, PW'(sb.contents.size() - 1), 0);
		send_req(REQ_READ, PW'(sb.contents.size()), 0);
		send_req(REQ_DELETE, PW'(sb.contents.size()), 0);
		send_req(REQ_DELETE, PW'(sb.contents.size() - 1), 0);
		send_req(REQ_APPEND, 0, 32'sh6666_6666);
		for (int i = 0; i < 60; i++)
			random_item(25, 25, 25, 25);

		wait_for_results();
		repeat (CAPACITY + 16) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d results never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
